// File: rtl/core/bms_pkg.sv
// shared types, constants and a helper function of the bandit mode selector
package bms_pkg;

    // default parameter values
    localparam int MODES_DEF         = 2;
    localparam int STREAK_BITS_DEF   = 8;
    localparam int FRACTION_BITS_DEF = 32;

    // fixed field widths
    localparam int QUAL_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int EN_W      = 2;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 56;
    localparam int SEL_CNT_W = 32;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_NORM,
        OP_LOG,
        OP_DIVINIT,
        OP_DIV,
        OP_TREND,
        OP_MUL_GO,
        OP_MUL_WAIT,
        OP_QSUM,
        OP_POWINIT,
        OP_FINISH
    } op_t;

    // multiplier operand and destination select
    typedef enum logic [2:0] {
        MS_Q,
        MS_U,
        MS_P,
        MS_B,
        MS_S
    } mul_sel_t;

    typedef struct packed {
        op_t      op;
        mul_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic log_last;
        logic div_last;
        logic mul_done;
        logic two_modes;
        logic e_zero;
        logic e_lsb;
        logic e_hi_zero;
        logic out_free;
    } status_t;

    // round(pct/100 * 2^f)
    function automatic logic [63:0] fx_const(input int unsigned pct, input int unsigned f);
        logic [63:0] num;
        num = (64'(pct) << f) + 64'd50;
        return num / 64'd100;
    endfunction

endpackage

// File: rtl/core/bms_mul.sv
// multi-cycle unsigned multiplier, 16-bit digit per cycle, rounded shift by the fraction
module bms_mul #(
    parameter int A_W = 48,
    parameter int B_W = 33,
    parameter int FRAC = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [A_W-1:0] res
);
    localparam int DIG = 16;
    localparam int ND = (B_W + DIG - 1) / DIG;
    localparam int KW = (ND > 1) ? $clog2(ND) : 1;
    localparam int PW = A_W + ND * DIG;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC - 1);

    logic [A_W-1:0]    a_reg;
    logic [ND*DIG-1:0] b_reg;
    logic [KW-1:0]     k_reg;
    logic [PW-1:0]     acc_reg;
    logic [A_W-1:0]    res_reg;
    logic              run_reg, rnd_reg, done_reg;

    logic [DIG-1:0]     digit;
    logic [A_W+DIG-1:0] partial;
    logic [PW-1:0]      rounded;

    // one partial product per cycle
    always_comb begin
        digit   = b_reg[k_reg*DIG +: DIG];
        partial = (A_W+DIG)'(a_reg) * (A_W+DIG)'(digit);
        rounded = acc_reg + HALF;
    end

    // sequencing flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            run_reg  <= 1'b1;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (run_reg) begin
            if (k_reg == KW'(ND - 1)) begin
                run_reg <= 1'b0;
                rnd_reg <= 1'b1;
            end
        end else if (rnd_reg) begin
            rnd_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    // operands and accumulator
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= (ND*DIG)'(b);
            k_reg   <= '0;
            acc_reg <= '0;
        end else if (run_reg) begin
            acc_reg <= acc_reg + (PW'(partial) << (DIG * k_reg));
            k_reg   <= k_reg + KW'(1);
        end else if (rnd_reg) begin
            res_reg <= A_W'(rounded >> FRAC);
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: rtl/core/bms_datapath.sv
// datapath: log, divider, quality update, power, selection and mode state
module bms_datapath #(
    parameter int MODES = bms_pkg::MODES_DEF,
    parameter int STREAK_BITS = bms_pkg::STREAK_BITS_DEF,
    parameter int FRACTION_BITS = bms_pkg::FRACTION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bms_pkg::cmd_t                    cmd,
    output bms_pkg::status_t                 status,
    input  logic [bms_pkg::IN_DATA_W-1:0]    in_data,
    input  logic                             cfg_we,
    input  logic [bms_pkg::EN_W-1:0]         cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bms_pkg::OUT_DATA_W-1:0]   out_data
);
    import bms_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int LW = F + 6;
    localparam int CW = $clog2(LW);
    localparam int UW = LW + 3;
    localparam int BW = F + 1;
    localparam int AW = QUAL_W;
    localparam int SW = QUAL_W + 1;
    localparam logic [BW-1:0] K085 = BW'(fx_const(85, F));
    localparam logic [BW-1:0] K015 = BW'(fx_const(15, F));
    localparam logic [BW-1:0] K098 = BW'(fx_const(98, F));
    localparam logic [BW-1:0] K092 = BW'(fx_const(92, F));
    localparam logic [BW-1:0] ONE  = BW'(1) << F;
    localparam logic [STREAK_BITS-1:0] STREAK_MAX = '1;

    // mode state
    logic [EN_W-1:0]          enabled_reg;
    logic                     cur_reg;
    logic [STREAK_BITS-1:0]   streak_reg;
    logic signed [QUAL_W-1:0] quality0_reg, quality1_reg;
    logic [LW-1:0]            prev0_reg, prev1_reg;
    logic [SEL_CNT_W-1:0]     sel_cnt0_reg, sel_cnt1_reg;
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    // per-item working registers
    logic [32:0]              x_reg, dv_reg;
    logic [31:0]              m_reg;
    logic [5:0]               n_reg;
    logic [F-1:0]             frac_reg;
    logic [CW-1:0]            cnt_reg;
    logic [33:0]              rem_reg;
    logic [LW-1:0]            quo_reg;
    logic                     tpos_reg;
    logic signed [UW-1:0]     u_reg;
    logic signed [SW-1:0]     term1_reg, term2_reg, score_reg;
    logic signed [QUAL_W-1:0] q_reg;
    logic [BW-1:0]            p_reg, base_reg;
    logic [STREAK_BITS-1:0]   e_reg;
    logic                     neg_reg;

    // combinational helpers
    logic [5:0]               lead;
    logic [63:0]              norm_sh;
    logic [63:0]              sq;
    logic [32:0]              sq_top;
    logic [33:0]              rem_sh;
    logic                     rem_ge;
    logic signed [QUAL_W-1:0] qcur;
    logic [LW-1:0]            prev_cur;
    logic signed [LW:0]       trend;
    logic signed [UW-1:0]     u_val;
    logic [QUAL_W-1:0]        qcur_mag, q_mag;
    logic [UW-1:0]            u_mag;
    logic                     mul_start, mul_done;
    logic [AW-1:0]            mul_a, mul_res;
    logic [BW-1:0]            mul_b;
    logic                     mul_neg;
    logic signed [SW-1:0]     mul_sval;
    logic signed [SW:0]       qsum;
    logic                     sat_hi, sat_lo;
    logic signed [QUAL_W-1:0] q_sat;
    logic                     two_modes, none_enabled;
    logic                     best, changed;

    // leading one of x and normalized mantissa
    always_comb begin
        lead = '0;
        for (int i = 0; i < 33; i++) begin
            if (x_reg[i]) lead = 6'(i);
        end
        norm_sh = {x_reg, 31'b0} >> lead;
    end

    // log step, divide step, trend
    always_comb begin
        sq       = 64'(m_reg) * 64'(m_reg);
        sq_top   = sq[63:31];
        rem_sh   = {rem_reg[32:0], quo_reg[LW-1]};
        rem_ge   = rem_sh >= {1'b0, dv_reg};
        qcur     = cur_reg ? quality1_reg : quality0_reg;
        prev_cur = cur_reg ? prev1_reg : prev0_reg;
        trend    = $signed({1'b0, quo_reg}) - $signed({1'b0, prev_cur});
        u_val    = $signed(UW'(quo_reg)) + $signed({trend[LW], trend, 1'b0});
        qcur_mag = qcur[QUAL_W-1] ? (~qcur + 1'b1) : qcur;
        q_mag    = q_reg[QUAL_W-1] ? (~q_reg + 1'b1) : q_reg;
        u_mag    = u_reg[UW-1] ? (~u_reg + 1'b1) : u_reg;
    end

    // multiplier operand select
    always_comb begin
        mul_start = (cmd.op == OP_MUL_GO);
        case (cmd.sel)
            MS_Q: begin
                mul_a = qcur_mag;  mul_b = K085;     mul_neg = qcur[QUAL_W-1];
            end
            MS_U: begin
                mul_a = AW'(u_mag); mul_b = K015;    mul_neg = u_reg[UW-1];
            end
            MS_P: begin
                mul_a = AW'(p_reg); mul_b = base_reg; mul_neg = 1'b0;
            end
            MS_B: begin
                mul_a = AW'(base_reg); mul_b = base_reg; mul_neg = 1'b0;
            end
            MS_S: begin
                mul_a = q_mag;     mul_b = p_reg;    mul_neg = q_reg[QUAL_W-1];
            end
            default: begin
                mul_a = '0;        mul_b = '0;       mul_neg = 1'b0;
            end
        endcase
        mul_sval = neg_reg ? -$signed({1'b0, mul_res}) : $signed({1'b0, mul_res});
    end

    bms_mul #(
        .A_W (AW),
        .B_W (BW),
        .FRAC(F)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .res    (mul_res)
    );

    // quality sum with saturation, mode selection
    always_comb begin
        qsum   = $signed({term1_reg[SW-1], term1_reg}) + $signed({term2_reg[SW-1], term2_reg});
        sat_hi = !qsum[SW] && (qsum[SW-1:QUAL_W-1] != 2'b00);
        sat_lo = qsum[SW] && (qsum[SW-1:QUAL_W-1] != 2'b11);
        if (sat_hi)      q_sat = {1'b0, {(QUAL_W-1){1'b1}}};
        else if (sat_lo) q_sat = {1'b1, {(QUAL_W-1){1'b0}}};
        else             q_sat = qsum[QUAL_W-1:0];
        two_modes    = (MODES >= 2) && enabled_reg[1];
        none_enabled = (enabled_reg == '0);
        if (none_enabled) begin
            best = cur_reg;
        end else if (!two_modes) begin
            best = 1'b0;
        end else if (!cur_reg) begin
            best = $signed({quality1_reg[QUAL_W-1], quality1_reg}) > score_reg;
        end else begin
            best = score_reg > $signed({quality0_reg[QUAL_W-1], quality0_reg});
        end
        changed = best != cur_reg;
    end

    // status to the controller
    always_comb begin
        status.log_last  = cnt_reg == CW'(F - 1);
        status.div_last  = cnt_reg == CW'(LW - 1);
        status.mul_done  = mul_done;
        status.two_modes = two_modes;
        status.e_zero    = e_reg == '0;
        status.e_lsb     = e_reg[0];
        status.e_hi_zero = e_reg[STREAK_BITS-1:1] == '0;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // mode state, configuration and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= EN_W'(2);
            cur_reg       <= 1'b0;
            streak_reg    <= '0;
            quality0_reg  <= '0;
            quality1_reg  <= '0;
            prev0_reg     <= '0;
            prev1_reg     <= '0;
            sel_cnt0_reg  <= '0;
            sel_cnt1_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) enabled_reg <= cfg_data;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_TREND: begin
                    if (cur_reg) prev1_reg <= quo_reg;
                    else         prev0_reg <= quo_reg;
                end
                OP_QSUM: begin
                    if (cur_reg) quality1_reg <= q_sat;
                    else         quality0_reg <= q_sat;
                end
                OP_FINISH: begin
                    out_valid_reg <= 1'b1;
                    cur_reg       <= best;
                    if (changed) streak_reg <= '0;
                    else if (streak_reg != STREAK_MAX) streak_reg <= streak_reg + 1'b1;
                    if (best) sel_cnt1_reg <= sel_cnt1_reg + 1'b1;
                    else      sel_cnt0_reg <= sel_cnt0_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                x_reg  <= {1'b0, in_data[COUNT_W-1:0]} + 33'd1;
                dv_reg <= {1'b0, in_data[2*COUNT_W-1:COUNT_W]} + 33'd1;
            end
            OP_NORM: begin
                n_reg   <= lead;
                m_reg   <= norm_sh[31:0];
                frac_reg <= '0;
                cnt_reg <= '0;
            end
            OP_LOG: begin
                m_reg    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
                frac_reg <= {frac_reg[F-2:0], sq_top[32]};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            OP_DIVINIT: begin
                rem_reg <= '0;
                quo_reg <= {n_reg, frac_reg};
                cnt_reg <= '0;
            end
            OP_DIV: begin
                rem_reg <= rem_ge ? (rem_sh - {1'b0, dv_reg}) : rem_sh;
                quo_reg <= {quo_reg[LW-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_TREND: begin
                u_reg    <= u_val;
                tpos_reg <= !trend[LW] && (trend != '0);
            end
            OP_MUL_GO: begin
                neg_reg <= mul_neg;
            end
            OP_MUL_WAIT: begin
                if (mul_done) begin
                    case (cmd.sel)
                        MS_Q: term1_reg <= mul_sval;
                        MS_U: term2_reg <= mul_sval;
                        MS_P: p_reg     <= BW'(mul_res);
                        MS_B: begin
                            base_reg <= BW'(mul_res);
                            e_reg    <= e_reg >> 1;
                        end
                        MS_S: score_reg <= mul_sval;
                        default: begin
                        end
                    endcase
                end
            end
            OP_QSUM: begin
                q_reg <= q_sat;
            end
            OP_POWINIT: begin
                p_reg    <= ONE;
                base_reg <= tpos_reg ? K098 : K092;
                e_reg    <= streak_reg;
            end
            OP_FINISH: begin
                out_data_reg <= {{(OUT_DATA_W - QUAL_W - 2){1'b0}}, q_reg, changed, best};
            end
            default: begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/bms_ctrl.sv
// controller state machine sequencing one item through the datapath
module bms_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bms_pkg::status_t  status,
    output bms_pkg::cmd_t     cmd
);
    import bms_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_DIVINIT,
        ST_DIV,
        ST_TREND,
        ST_MQ_GO,
        ST_MQ_WAIT,
        ST_MU_GO,
        ST_MU_WAIT,
        ST_QSUM,
        ST_POWINIT,
        ST_POWCHK,
        ST_PMUL_GO,
        ST_PMUL_WAIT,
        ST_POWNEXT,
        ST_BMUL_GO,
        ST_BMUL_WAIT,
        ST_SMUL_GO,
        ST_SMUL_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = MS_Q;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                cmd.op     = OP_NORM;
                state_next = ST_LOG;
            end
            ST_LOG: begin
                cmd.op = OP_LOG;
                if (status.log_last) state_next = ST_DIVINIT;
            end
            ST_DIVINIT: begin
                cmd.op     = OP_DIVINIT;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (status.div_last) state_next = ST_TREND;
            end
            ST_TREND: begin
                cmd.op     = OP_TREND;
                state_next = ST_MQ_GO;
            end
            ST_MQ_GO: begin
                cmd.op     = OP_MUL_GO;
                cmd.sel    = MS_Q;
                state_next = ST_MQ_WAIT;
            end
            ST_MQ_WAIT: begin
                cmd.op  = OP_MUL_WAIT;
                cmd.sel = MS_Q;
                if (status.mul_done) state_next = ST_MU_GO;
            end
            ST_MU_GO: begin
                cmd.op     = OP_MUL_GO;
                cmd.sel    = MS_U;
                state_next = ST_MU_WAIT;
            end
            ST_MU_WAIT: begin
                cmd.op  = OP_MUL_WAIT;
                cmd.sel = MS_U;
                if (status.mul_done) state_next = ST_QSUM;
            end
            ST_QSUM: begin
                cmd.op     = OP_QSUM;
                state_next = status.two_modes ? ST_POWINIT : ST_FINISH;
            end
            ST_POWINIT: begin
                cmd.op     = OP_POWINIT;
                state_next = ST_POWCHK;
            end
            ST_POWCHK: begin
                if (status.e_zero)     state_next = ST_SMUL_GO;
                else if (status.e_lsb) state_next = ST_PMUL_GO;
                else                   state_next = ST_BMUL_GO;
            end
            ST_PMUL_GO: begin
                cmd.op     = OP_MUL_GO;
                cmd.sel    = MS_P;
                state_next = ST_PMUL_WAIT;
            end
            ST_PMUL_WAIT: begin
                cmd.op  = OP_MUL_WAIT;
                cmd.sel = MS_P;
                if (status.mul_done) state_next = ST_POWNEXT;
            end
            ST_POWNEXT: begin
                state_next = status.e_hi_zero ? ST_SMUL_GO : ST_BMUL_GO;
            end
            ST_BMUL_GO: begin
                cmd.op     = OP_MUL_GO;
                cmd.sel    = MS_B;
                state_next = ST_BMUL_WAIT;
            end
            ST_BMUL_WAIT: begin
                cmd.op  = OP_MUL_WAIT;
                cmd.sel = MS_B;
                if (status.mul_done) state_next = ST_POWCHK;
            end
            ST_SMUL_GO: begin
                cmd.op     = OP_MUL_GO;
                cmd.sel    = MS_S;
                state_next = ST_SMUL_WAIT;
            end
            ST_SMUL_WAIT: begin
                cmd.op  = OP_MUL_WAIT;
                cmd.sel = MS_S;
                if (status.mul_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// File: rtl/core/bandit_mode_selector.sv
// top level of the bandit mode selector
//
// Each item closes one phase and carries its conflict and decision counts. The block forms
// the reward log2(conflicts+1)/(decisions+1), updates the quality of the active mode and
// returns the mode for the next phase with the updated quality, one result per item. One
// item is in work at a time. An item is captured and normalized, then passes through the
// bit-serial log (one squaring per cycle) and the restoring divider with its setup, and then
// through products on one shared multiplier that takes 16 bits of its second operand per
// cycle: two for the quality update and, with both modes enabled, up to two per streak bit
// plus one for the active score, the most at a streak of all ones. A finished result waits
// in the output register while the next item is accepted. enabled_modes may be written
// only while no item is in work.
module bandit_mode_selector #(
    parameter int MODES = bms_pkg::MODES_DEF,
    parameter int STREAK_BITS = bms_pkg::STREAK_BITS_DEF,
    parameter int FRACTION_BITS = bms_pkg::FRACTION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // item in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bms_pkg::IN_DATA_W-1:0]    s_tdata,  // conflict_count, decision_count
    // result out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bms_pkg::OUT_DATA_W-1:0]   m_tdata,  // selected_mode, mode_changed,
                                                       // new_quality, zero fill
    // enabled_modes register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bms_pkg::EN_W-1:0]         cfg_data
);
    import bms_pkg::*;

    cmd_t    cmd;
    status_t status;

    bms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    bms_datapath #(
        .MODES        (MODES),
        .STREAK_BITS  (STREAK_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

    // register write always taken
    assign cfg_ready = 1'b1;

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the bandit mode selector with its own quality and score predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bms_pkg::*;

    localparam int  HALF_PERIOD = 6;
    localparam int  IDLE_LIMIT  = 20000;
    localparam int  LONG_HOLD   = 3000;
    localparam int  DRAIN_WAIT  = 250;
    localparam logic [63:0] K_085 = ((64'd85 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_015 = ((64'd15 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_098 = ((64'd98 << 32) + 64'd50) / 64'd100;
    localparam logic [63:0] K_092 = ((64'd92 << 32) + 64'd50) / 64'd100;
    localparam logic signed [63:0] Q_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] Q_MIN = -Q_MAX - 64'sd1;
    localparam logic [7:0] STREAK_TOP = 8'hFF;

    typedef struct packed {
        logic        mode;
        logic        changed;
        logic [47:0] quality;
    } sel_result_t;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  cfg;
        logic [31:0] conflicts;
        logic [31:0] decisions;
        logic        fixed;
        sel_result_t res;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [EN_W-1:0]       cfg_data = '0;

    // predictor state
    logic [1:0]             pm_enabled;
    logic                   pm_active;
    logic signed [63:0]     pm_quality [2];
    logic [63:0]            pm_prev_reward [2];
    logic [7:0]             pm_streak;

    sel_result_t expected_sel[$];
    int  errors = 0;
    bit  idle_on = 1'b1;
    bit  long_req = 1'b0;
    int  hold_cnt = 0;
    int  quiet_cycles = 0;

    bandit_mode_selector u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // unsigned product rounded to nearest, scaled down by the fraction bits
    function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << 31);
        return p[95:32];
    endfunction

    // signed times nonnegative constant, rounded on the magnitude
    function automatic logic signed [63:0] signed_mul(input logic signed [63:0] a,
                                                      input logic [63:0] k);
        logic [63:0] mag;
        logic [63:0] r;
        mag = (a < 0) ? -a : a;
        r = round_mul(mag, k);
        return (a < 0) ? -$signed(r) : $signed(r);
    endfunction

    // truncated log2 with 32 fraction bits, bit-serial by squaring
    function automatic logic [63:0] log2_fixed(input logic [32:0] x);
        int n;
        logic [63:0] m;
        logic [63:0] frac;
        n = 0;
        frac = '0;
        while (n < 32 && (x >> (n + 1)) != 0) n++;
        m = (n <= 31) ? ({31'd0, x} << (31 - n)) : ({31'd0, x} >> 1);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(n) << 32) | frac;
    endfunction

    // decay factor raised to the streak, square and multiply from the low bit
    function automatic logic [63:0] decay_pow(input logic [63:0] base, input logic [7:0] e);
        logic [63:0] p;
        p = 64'd1 << 32;
        while (e != 0) begin
            if (e[0]) p = round_mul(p, base);
            base = round_mul(base, base);
            e = e >> 1;
        end
        return p;
    endfunction

    // quality update and mode selection for one finished phase
    function automatic sel_result_t predict_selection(input logic [31:0] c, input logic [31:0] d);
        sel_result_t o;
        logic               cur;
        logic               best;
        int                 n;
        logic [63:0]        r;
        logic signed [63:0] t;
        logic signed [63:0] q;
        logic signed [63:0] sc [2];
        logic signed [63:0] best_sc;
        logic [63:0]        lam;
        cur = pm_active;
        best = cur;
        n = (pm_enabled > 2) ? 2 : int'(pm_enabled);
        r = log2_fixed({1'b0, c} + 33'd1) / ({32'd0, d} + 64'd1);
        t = $signed(r) - $signed(pm_prev_reward[cur]);
        pm_prev_reward[cur] = r;
        q = signed_mul(pm_quality[cur], K_085) + signed_mul($signed(r) + 2 * t, K_015);
        if (q > Q_MAX) q = Q_MAX;
        if (q < Q_MIN) q = Q_MIN;
        pm_quality[cur] = q;
        lam = (t > 0) ? K_098 : K_092;
        for (int i = 0; i < n; i++)
            sc[i] = (i == cur) ? signed_mul(q, decay_pow(lam, pm_streak)) : pm_quality[i];
        if (n > 0) begin
            best = 1'b0;
            best_sc = sc[0];
            if (n > 1 && sc[1] > best_sc) best = 1'b1;
        end
        if (best != cur) pm_streak = '0;
        else if (pm_streak < STREAK_TOP) pm_streak = pm_streak + 8'd1;
        pm_active = best;
        o.mode = best;
        o.changed = (best != cur);
        o.quality = q[47:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checking at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_sel.size() == 0) begin
                report_mismatch("unexpected item", 64'(m_tdata), 64'd0);
            end else begin
                sel_result_t e;
                e = expected_sel.pop_front();
                if (m_tdata[0] !== e.mode) report_mismatch("selected_mode", 64'(m_tdata[0]),
                                                           64'(e.mode));
                if (m_tdata[1] !== e.changed)
                    report_mismatch("mode_changed", 64'(m_tdata[1]), 64'(e.changed));
                if (m_tdata[49:2] !== e.quality)
                    report_mismatch("new_quality", 64'(m_tdata[49:2]), 64'(e.quality));
                if (m_tdata[OUT_DATA_W-1:50] !== '0)
                    report_mismatch("zero fill", 64'(m_tdata[OUT_DATA_W-1:50]), 64'd0);
            end
        end
    end

    // receiver: random short holds, one long hold on request
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (long_req) begin
            long_req = 1'b0;
            hold_cnt = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_cnt = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_phase(input logic [31:0] c, input logic [31:0] d, input bit fixed,
                              input sel_result_t fixed_res);
        sel_result_t p;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {d, c};
        do @(posedge aclk); while (!s_tready);
        p = predict_selection(c, d);
        expected_sel.push_back(fixed ? fixed_res : p);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_sel.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_enabled(input logic [1:0] v);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        pm_enabled = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_conflicts();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return $urandom_range(1000, 100000);
        endcase
    endfunction

    function automatic logic [31:0] rand_decisions();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1, 2: return $urandom_range(0, 15);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    stim_row_t directed [] = '{
        '{1'b0, 2'd0, 32'd0,          32'd0,          1'b1, '{1'b0, 1'b0, 48'd0}},
        '{1'b0, 2'd0, 32'hFFFF_FFFF,  32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, '0},
        '{1'b0, 2'd0, 32'd0,          32'hFFFF_FFFF,  1'b0, '0},
        '{1'b0, 2'd0, 32'hFFFF_FFFF,  32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd1000,       32'd3,          1'b0, '0},
        '{1'b0, 2'd0, 32'd50,         32'd200,        1'b0, '0},
        '{1'b1, 2'd1, 32'd0,          32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'hFFFF_FFFF,  32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd0,          32'd0,          1'b0, '0},
        '{1'b1, 2'd0, 32'd0,          32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd7,          32'd1,          1'b0, '0},
        '{1'b0, 2'd0, 32'hFFFF_FFFF,  32'd0,          1'b0, '0},
        '{1'b1, 2'd3, 32'd0,          32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd100,        32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd0,          32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd5000,       32'd2,          1'b0, '0},
        '{1'b1, 2'd2, 32'd0,          32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'hFFFF_FFFF,  32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd0,          32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd0,          32'd0,          1'b0, '0},
        '{1'b0, 2'd0, 32'd123456,     32'd10,         1'b0, '0}
    };

    logic [1:0] seg_cfg [10] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2};

    // main sequence
    initial begin
        pm_enabled = 2'd2;
        pm_active = 1'b0;
        pm_quality[0] = 0;
        pm_quality[1] = 0;
        pm_prev_reward[0] = '0;
        pm_prev_reward[1] = '0;
        pm_streak = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed[i]) begin
            if (directed[i].is_cfg) write_enabled(directed[i].cfg);
            else send_phase(directed[i].conflicts, directed[i].decisions, directed[i].fixed,
                            directed[i].res);
        end

        // random segments across enabled-mode settings
        for (int s = 0; s < 10; s++) begin
            write_enabled(seg_cfg[s]);
            if (s == 9) idle_on = 1'b0;
            if (s == 2) long_req = 1'b1;
            for (int k = 0; k < 140; k++) begin
                if (s == 4 && k == 70) drain_results();
                send_phase(rand_conflicts(), rand_decisions(), 1'b0, '0);
            end
        end

        drain_results();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
